// ===== rtl/gbn_pkg.sv =====
`default_nettype none
package gbn_pkg;
   localparam int MAX_KEPT_DEF = 64;
   localparam logic [7:0] THRESH_RESET = 8'd64;
   localparam int SLOT_W = 6;
   localparam int FIFO_DEPTH = 2;

   typedef struct packed {
      logic               first_of_set;
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_wide;
      logic [14:0]        box_tall;
   } box_item_type;

   typedef struct packed {
      logic              keep;
      logic [SLOT_W-1:0] kept_slot;
      logic              list_full;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_OVL,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } back_state_type;
endpackage
`default_nettype wire

// ===== rtl/gbn_ram.sv =====
`default_nettype none
module gbn_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/gbn_front.sv =====
`default_nettype none
module gbn_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   output logic                 full,
   input  wire gbn_pkg::box_item_type push_item,
   input  wire                  take,
   output logic                 avail,
   output gbn_pkg::box_item_type head_item
);
   localparam int AW = $clog2(gbn_pkg::FIFO_DEPTH);

   gbn_pkg::box_item_type q_ff [gbn_pkg::FIFO_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          do_push, do_take;

   assign full      = (cnt_ff == (AW+1)'(gbn_pkg::FIFO_DEPTH));
   assign avail     = (cnt_ff != '0);
   assign head_item = q_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_take   = take && avail;

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= push_item;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_take);
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(gbn_pkg::FIFO_DEPTH)) else $error("queue count overflow");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_take |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
   a_take_shrink: assert property (@(posedge clock) disable iff (reset)
      do_take && !do_push |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("take lost");
endmodule
`default_nettype wire

// ===== rtl/gbn_back.sv =====
`default_nettype none
module gbn_back #(
   parameter int MAX_KEPT = gbn_pkg::MAX_KEPT_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [7:0]             thresh,
   input  wire                   avail,
   input  wire gbn_pkg::box_item_type head_item,
   output logic                  take,
   output logic                  rsp_valid,
   output gbn_pkg::rsp_item_type rsp_item,
   input  wire                   rsp_taken
);
   localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int BW = 62;

   gbn_pkg::back_state_type st_ff, st_in;
   gbn_pkg::box_item_type   cur_ff;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic          keep_ff, keep_in;
   logic [BW-1:0] rd_data;
   logic [16:0]   ow_ff, oh_ff;
   logic [14:0]   bw_ff, bh_ff;
   logic [33:0]   inter_ff;
   logic [29:0]   area_b_ff, area_a_ff;
   logic          wr_en;
   logic [IW-1:0] rd_addr;
   gbn_pkg::rsp_item_type res_ff, res_in;
   logic          rv_ff, rv_in;
   logic signed [15:0] bl, bt;
   logic signed [17:0] s0, e0, s1, e1, aw_end, bw_end, ah_end, bh_end;
   logic [41:0]   lhs;
   logic [41:0]   rhs;
   logic [31:0]   uni;
   logic          cnt_lt;

   assign bl = rd_data[61:46];
   assign bt = rd_data[45:30];
   assign cnt_lt = (cnt_ff < CW'(MAX_KEPT));
   assign rd_addr = idx_ff[IW-1:0];

   gbn_ram #(.WIDTH(BW), .DEPTH(MAX_KEPT)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(cnt_ff[IW-1:0]),
      .wr_data({cur_ff.box_left, cur_ff.box_top, cur_ff.box_wide, cur_ff.box_tall}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      aw_end = 18'(cur_ff.box_left) + 18'(signed'({1'b0, cur_ff.box_wide}));
      bw_end = 18'(bl) + 18'(signed'({1'b0, rd_data[29:15]}));
      ah_end = 18'(cur_ff.box_top) + 18'(signed'({1'b0, cur_ff.box_tall}));
      bh_end = 18'(bt) + 18'(signed'({1'b0, rd_data[14:0]}));
      s0 = (cur_ff.box_left > bl) ? 18'(cur_ff.box_left) : 18'(bl);
      e0 = (aw_end < bw_end) ? aw_end : bw_end;
      s1 = (cur_ff.box_top > bt) ? 18'(cur_ff.box_top) : 18'(bt);
      e1 = (ah_end < bh_end) ? ah_end : bh_end;
      uni = 32'(area_a_ff) + 32'(area_b_ff) - 32'(inter_ff);
      lhs = {inter_ff, 8'b0};
      rhs = 42'(thresh) * 42'(uni);
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      keep_in = keep_ff;
      res_in  = res_ff;
      rv_in   = rv_ff;
      take    = 1'b0;
      wr_en   = 1'b0;
      if (rv_ff && rsp_taken) rv_in = 1'b0;
      unique case (st_ff)
         gbn_pkg::ST_IDLE: begin
            if (avail) begin
               take    = 1'b1;
               keep_in = 1'b1;
               idx_in  = '0;
               if (head_item.first_of_set) cnt_in = '0;
               st_in = gbn_pkg::ST_READ;
            end
         end
         gbn_pkg::ST_READ: begin
            if (idx_ff < cnt_ff && keep_ff) st_in = gbn_pkg::ST_OVL;
            else st_in = gbn_pkg::ST_DONE;
         end
         gbn_pkg::ST_OVL: st_in = gbn_pkg::ST_MUL;
         gbn_pkg::ST_MUL: st_in = gbn_pkg::ST_CMP;
         gbn_pkg::ST_CMP: begin
            if (lhs > rhs) keep_in = 1'b0;
            idx_in = idx_ff + 1'b1;
            st_in  = gbn_pkg::ST_READ;
         end
         gbn_pkg::ST_DONE: begin
            if (!rv_in) begin
               rv_in = 1'b1;
               res_in = '0;
               if (keep_ff) begin
                  res_in.keep = 1'b1;
                  if (cnt_lt) begin
                     wr_en = 1'b1;
                     res_in.kept_slot = gbn_pkg::SLOT_W'(cnt_ff);
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     res_in.list_full = 1'b1;
                  end
               end
               st_in = gbn_pkg::ST_IDLE;
            end
         end
         default: st_in = gbn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) cur_ff <= head_item;
      ow_ff <= (e0 > s0) ? 17'(e0 - s0) : '0;
      oh_ff <= (e1 > s1) ? 17'(e1 - s1) : '0;
      bw_ff <= rd_data[29:15];
      bh_ff <= rd_data[14:0];
      inter_ff  <= 34'(ow_ff) * 34'(oh_ff);
      area_b_ff <= bw_ff * bh_ff;
      area_a_ff <= cur_ff.box_wide * cur_ff.box_tall;
      idx_ff  <= idx_in;
      keep_ff <= keep_in;
      res_ff  <= res_in;
      if (reset) begin
         st_ff  <= gbn_pkg::ST_IDLE;
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         rv_ff  <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_item  = res_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_KEPT)) else $error("kept count overflow");
   a_full_keep: assert property (@(posedge clock) disable iff (reset)
      rv_ff && res_ff.list_full |-> res_ff.keep && res_ff.kept_slot == '0)
      else $error("full flag without keep");
   a_write_grow: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("write without append");
endmodule
`default_nettype wire

// ===== rtl/greedy_box_nms_unit.sv =====
// channel   direction  handshake          payload
// req_      in         push / full        first_of_set, box_left/top/wide/tall
// rsp_      out        empty / pop        keep, kept_slot, list_full
// csr_      in         valid / ready      iou_threshold
// In the back end an item runs the read/overlap/multiply/compare loop over the kept-box
// RAM, one pass per kept box compared; suppression ends it early.
// A two-entry queue takes new items while one is processed; the result
// register holds a result until popped and the back end waits on it.
// Reset is synchronous: kept list empties, threshold returns to 0.25.
`default_nettype none
module greedy_box_nms_unit #(
   parameter int MAX_KEPT = gbn_pkg::MAX_KEPT_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  wire               req_first_of_set,
   input  wire signed [15:0] req_box_left,
   input  wire signed [15:0] req_box_top,
   input  wire [14:0]        req_box_wide,
   input  wire [14:0]        req_box_tall,
   output logic              empty,
   input  wire               pop,
   output logic              rsp_keep,
   output logic [5:0]        rsp_kept_slot,
   output logic              rsp_list_full,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [7:0]         csr_iou_threshold
);
   logic [7:0] thresh_ff;
   logic avail, take, rv;
   gbn_pkg::box_item_type head, pin;
   gbn_pkg::rsp_item_type ri;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= gbn_pkg::THRESH_RESET;
      else if (csr_valid) thresh_ff <= csr_iou_threshold;
   end

   assign pin = '{req_first_of_set, req_box_left, req_box_top, req_box_wide, req_box_tall};

   gbn_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .push_item(pin),
      .take(take), .avail(avail), .head_item(head)
   );

   gbn_back #(.MAX_KEPT(MAX_KEPT)) u_back (
      .clock(clock), .reset(reset), .thresh(thresh_ff), .avail(avail),
      .head_item(head), .take(take), .rsp_valid(rv), .rsp_item(ri),
      .rsp_taken(pop)
   );

   assign empty         = !rv;
   assign rsp_keep      = ri.keep;
   assign rsp_kept_slot = ri.kept_slot;
   assign rsp_list_full = ri.list_full;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;

   localparam int KEPT_MAX = 64;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic               first;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        wide;
      logic [14:0]        tall;
   } nms_box_type;

   class nms_scoreboard;
      nms_box_type  kept_list[KEPT_MAX];
      int           kept_num;
      logic [7:0]   thresh;
      gbn_pkg::rsp_item_type verdicts[$];
      int           errors;
      int           checked;
      int           kept_total;
      int           full_total;

      function new();
         kept_num = 0;
         thresh = gbn_pkg::THRESH_RESET;
         errors = 0;
         checked = 0;
         kept_total = 0;
         full_total = 0;
      endfunction

      function longint span(longint a0, longint alen, longint b0, longint blen);
         longint lo;
         longint hi;
         lo = (a0 > b0) ? a0 : b0;
         hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
         return (hi > lo) ? hi - lo : 0;
      endfunction

      function bit overlaps_too_much(nms_box_type a, nms_box_type b);
         longint iw;
         longint ih;
         longint inter;
         longint uni;
         iw = span(a.left, a.wide, b.left, b.wide);
         ih = span(a.top, a.tall, b.top, b.tall);
         inter = iw * ih;
         uni = longint'(a.wide) * a.tall + longint'(b.wide) * b.tall - inter;
         return inter * 256 > longint'(thresh) * uni;
      endfunction

      function void note_box(nms_box_type b);
         gbn_pkg::rsp_item_type r;
         bit survive;
         if (b.first)
            kept_num = 0;
         survive = 1;
         for (int j = 0; j < kept_num; j++)
            if (overlaps_too_much(b, kept_list[j]))
               survive = 0;
         r = '0;
         if (survive) begin
            r.keep = 1;
            if (kept_num < KEPT_MAX) begin
               kept_list[kept_num] = b;
               r.kept_slot = kept_num[5:0];
               kept_num++;
            end else begin
               r.list_full = 1;
            end
         end
         verdicts = {verdicts, r};
      endfunction

      function void check_verdict(gbn_pkg::rsp_item_type got);
         gbn_pkg::rsp_item_type want;
         checked++;
         if (verdicts.size() == 0) begin
            report_error("result with nothing pending");
            return;
         end
         want = verdicts.pop_front();
         if (got.keep) kept_total++;
         if (got.list_full) full_total++;
         if (got.keep !== want.keep)
            report_error($sformatf("keep %0b want %0b", got.keep, want.keep));
         if (got.kept_slot !== want.kept_slot)
            report_error($sformatf("kept_slot %0d want %0d", got.kept_slot, want.kept_slot));
         if (got.list_full !== want.list_full)
            report_error($sformatf("list_full %0b want %0b", got.list_full, want.list_full));
      endfunction

      function void report_error(string msg);
         errors++;
         if (errors <= 40)
            $display("mismatch at result %0d: %s", checked, msg);
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               push = 0;
   wire                full;
   logic               req_first_of_set = 0;
   logic signed [15:0] req_box_left = 0;
   logic signed [15:0] req_box_top = 0;
   logic [14:0]        req_box_wide = 0;
   logic [14:0]        req_box_tall = 0;
   wire                empty;
   logic               pop = 0;
   wire                rsp_keep;
   wire [5:0]          rsp_kept_slot;
   wire                rsp_list_full;
   logic               csr_valid = 0;
   wire                csr_ready;
   logic [7:0]         csr_iou_threshold = 0;

   nms_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 0;
   bit  stim_done = 0;
   int  cycles = 0;
   int  sent = 0;

   greedy_box_nms_unit uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_first_of_set(req_first_of_set), .req_box_left(req_box_left),
      .req_box_top(req_box_top), .req_box_wide(req_box_wide),
      .req_box_tall(req_box_tall), .empty(empty), .pop(pop),
      .rsp_keep(rsp_keep), .rsp_kept_slot(rsp_kept_slot),
      .rsp_list_full(rsp_list_full), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_iou_threshold(csr_iou_threshold)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: pop at random, honor hold-off
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_verdict('{rsp_keep, rsp_kept_slot, rsp_list_full});
      if (reset || hold_off)
         pop <= 0;
      else
         pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_box(nms_box_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_first_of_set <= b.first;
      req_box_left <= b.left;
      req_box_top <= b.top;
      req_box_wide <= b.wide;
      req_box_tall <= b.tall;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_box(b);
      sent++;
   endtask

   task automatic write_threshold(logic [7:0] t);
      push <= 0;
      @(posedge clock);
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_valid <= 1;
      csr_iou_threshold <= t;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      sb.thresh = t;
   endtask

   function automatic nms_box_type mk(bit f, int l, int t, int w, int h);
      nms_box_type b;
      b.first = f;
      b.left = 16'(l);
      b.top = 16'(t);
      b.wide = 15'(w);
      b.tall = 15'(h);
      return b;
   endfunction

   // clustered boxes so overlaps happen; occasional full-range noise
   function automatic nms_box_type rand_box(bit f);
      nms_box_type b;
      b.first = f;
      if ($urandom_range(9) == 0) begin
         b.left = 16'($urandom);
         b.top = 16'($urandom);
         b.wide = 15'($urandom);
         b.tall = 15'($urandom);
      end else begin
         b.left = 16'($signed($urandom_range(1600)) - 800);
         b.top = 16'($signed($urandom_range(1600)) - 800);
         b.wide = 15'($urandom_range(640));
         b.tall = 15'($urandom_range(640));
      end
      return b;
   endfunction

   task automatic random_sets(int n);
      int left_in_set;
      left_in_set = 0;
      for (int i = 0; i < n; i++) begin
         if (left_in_set == 0)
            left_in_set = ($urandom_range(7) == 0) ? $urandom_range(100, 80)
                                                   : $urandom_range(30, 1);
         send_box(rand_box(i == 0 || left_in_set == 1 ? 1'b1 : 1'b0));
         left_in_set--;
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_box(mk(1, 0, 0, 160, 160));
      send_box(mk(0, 0, 0, 160, 160));
      send_box(mk(0, 80, 0, 160, 160));
      send_box(mk(0, -32768, -32768, 32767, 32767));
      send_box(mk(0, 32767, 32767, 32767, 32767));
      send_box(mk(1, 0, 0, 0, 0));
      send_box(mk(0, 0, 0, 0, 0));
      send_box(mk(0, -1, -1, 1, 1));
      send_box(mk(1, 100, 100, 0, 50));
      write_threshold(8'd0);
      send_box(mk(1, 0, 0, 32, 32));
      send_box(mk(0, 31, 31, 32, 32));
      send_box(mk(0, 32, 0, 32, 32));
      write_threshold(8'd255);
      send_box(mk(1, 0, 0, 32, 32));
      send_box(mk(0, 1, 0, 32, 32));
      send_box(mk(0, 0, 0, 32, 32));
      // overfill the kept list
      send_box(mk(1, 0, 0, 16, 16));
      for (int i = 1; i < 70; i++)
         send_box(mk(0, i * 32, -i * 32, 16, 16));

      write_threshold(8'd64);
      send_idle_pct = 9;
      recv_idle_pct = 50;
      random_sets(300);
      hold_off = 1;
      random_sets(40);
      hold_off = 0;
      write_threshold(8'($urandom_range(254, 1)));
      send_idle_pct = 50;
      recv_idle_pct = 9;
      random_sets(400);
      write_threshold(8'd128);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_sets(350);
      write_threshold(8'd0);
      random_sets(150);
      write_threshold(8'd255);
      random_sets(150);

      push <= 0;
      stim_done = 1;
   end

   always @(posedge clock) begin
      if (hold_off) begin
         repeat (2000) @(posedge clock);
         hold_off = 0;
      end
   end

   initial begin
      @(posedge clock);
      wait (stim_done);
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d boxes, checked %0d results (%0d kept, %0d with list full)",
               sent, sb.checked, sb.kept_total, sb.full_total);
      $display("thresholds covered 0, 64, 128, 255 and a random one; %0d mismatches",
               sb.errors);
      if (sb.errors == 0 && sb.verdicts.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
